// ----- rtl/core/typed_binary_search_unit_assert.svh -----
// Assertion macros for the typed binary search unit
`ifndef TYPED_BINARY_SEARCH_UNIT_ASSERT_SVH
`define TYPED_BINARY_SEARCH_UNIT_ASSERT_SVH
// Check that a condition implies a consequence in the next cycle
`define TBS_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
// Check that a condition implies a consequence in the same cycle
`define TBS_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
`endif

// ----- rtl/core/tbs_pkg.sv -----
package tbs_pkg;
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [1:0] TYPE_INT32 = 2'd0;
    localparam logic [1:0] TYPE_CHAR8 = 2'd1;
    localparam logic [1:0] TYPE_FP32  = 2'd2;
    localparam logic [1:0] TYPE_FP64  = 2'd3;

    localparam logic REG_ELEM_TYPE = 1'b0;
    localparam logic REG_ELEM_COUNT = 1'b1;

    typedef struct packed {
        logic        op;
        logic [9:0]  load_index;
        logic [63:0] value;
    } t_req;

    typedef struct packed {
        logic       found;
        logic [9:0] position;
    } t_rsp;

    // Ordering key: integers sign-extended, float sign-magnitude mapped to two's complement, plus NaN flag
    typedef struct packed {
        logic        nan;
        logic [63:0] ord;
    } t_key;

    function automatic t_key make_key(input logic [1:0] etype, input logic [63:0] bits);
        t_key k;
        logic [63:0] mag;
        k.nan = 1'b0;
        mag   = '0;
        case (etype)
            TYPE_INT32: k.ord = {{32{bits[31]}}, bits[31:0]};
            TYPE_CHAR8: k.ord = {{56{bits[7]}}, bits[7:0]};
            TYPE_FP32: begin
                mag   = {33'd0, bits[30:0]};
                k.nan = bits[30:0] > 31'h7F800000;
                k.ord = bits[31] ? (64'd0 - mag) : mag;
            end
            default: begin
                mag   = {1'b0, bits[62:0]};
                k.nan = bits[62:0] > 63'h7FF0000000000000;
                k.ord = bits[63] ? (64'd0 - mag) : mag;
            end
        endcase
        return k;
    endfunction
endpackage

// ----- rtl/core/tbs_mem.sv -----
module tbs_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);
    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    // Write one entry, read one entry registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/tbs_search.sv -----
module tbs_search #(
    parameter int AW = 10,
    parameter int CW = 11
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_etype,
    input  logic [CW-1:0]  i_count,
    input  logic [63:0]    i_key,
    input  logic [63:0]    i_rdata,
    output logic [AW-1:0]  o_raddr,
    output logic           o_busy,
    output logic           o_done,
    output tbs_pkg::t_rsp  o_rsp
);
    import tbs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW:0]   r_lo, n_lo;     // signed start
    logic [CW:0]   r_hi, n_hi;     // signed end
    logic [CW:0]   r_mid, n_mid;
    t_key          r_key, n_key;
    logic [1:0]    r_etype;
    logic          r_done, n_done;
    t_rsp          r_rsp, n_rsp;
    t_key          ekey;
    logic [CW:0]   sum;
    logic          un;

    assign ekey = make_key(r_etype, i_rdata);
    assign un   = r_key.nan | ekey.nan;
    assign sum  = r_lo + r_hi;

    // Sequence probes: read midpoint, then compare
    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_key   = r_key;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_key   = make_key(i_etype, i_key);
                    n_lo    = '0;
                    n_hi    = {1'b0, i_count} - 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if ($signed(r_lo) <= $signed(r_hi)) begin
                    n_mid   = {1'b0, sum[CW:1]};
                    n_state = ST_CMP;
                end else begin
                    n_rsp   = '{found: 1'b0, position: '0};
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_CMP: begin
                if (!un && r_key.ord == ekey.ord) begin
                    n_rsp   = '{found: 1'b1, position: 10'(r_mid)};
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else if (!un && $signed(r_key.ord) > $signed(ekey.ord)) begin
                    n_lo    = r_mid + 1'b1;
                    n_state = ST_READ;
                end else begin
                    n_hi    = r_mid - 1'b1;
                    n_state = ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_key <= n_key;
        r_rsp <= n_rsp;
        if (i_start && r_state == ST_IDLE) begin
            r_etype <= i_etype;
        end
    end

    assign o_raddr = n_mid[AW-1:0];
    assign o_busy  = (r_state != ST_IDLE) | r_done;
    assign o_done  = r_done;
    assign o_rsp   = r_rsp;
endmodule

// ----- rtl/core/typed_binary_search_unit.sv -----
// Typed binary search unit. Load requests (op 0) write one 64-bit entry of
// the sorted array. Search requests (op 1) run a binary search over
// entries 0..element_count-1 (count clamped to MAX_ELEMENTS) using the
// configured element type, with one synchronous memory read per probe;
// each probe passes through a read state and then a compare state. The
// search ends at the first probe that matches the key, or without a match
// once the range is empty. One request is worked at a time; the next
// request waits until the response has been taken. Entries must be
// loaded before they are searched.
module typed_binary_search_unit #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  tbs_pkg::t_req      i_req,
    output logic               o_valid,
    input  logic               i_ready,
    output tbs_pkg::t_rsp      o_rsp,
    input  logic               i_cfg_we,
    input  logic [10:0]        i_cfg_index,
    input  logic [10:0]        i_cfg_data
);
    import tbs_pkg::*;

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = AW + 1;

    logic [1:0]    r_etype;
    logic [10:0]   r_count;
    logic [CW-1:0] count_cl;
    logic          r_ovalid;
    t_rsp          r_orsp;
    logic          accept, start, load_we, busy, done;
    logic [AW-1:0] raddr;
    logic [63:0]   rdata;
    t_rsp          srsp;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_etype <= TYPE_INT32;
            r_count <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == 11'(REG_ELEM_TYPE)) begin
                r_etype <= i_cfg_data[1:0];
            end else if (i_cfg_index == 11'(REG_ELEM_COUNT)) begin
                r_count <= i_cfg_data;
            end
        end
    end

    // Clamp count to the array depth
    always_comb begin
        if (32'(r_count) > MAX_ELEMENTS) begin
            count_cl = CW'(MAX_ELEMENTS);
        end else begin
            count_cl = CW'(r_count);
        end
    end

    assign o_ready = !busy && !r_ovalid;
    assign accept  = i_valid && o_ready;
    assign start   = accept && (i_req.op == OP_SEARCH);
    assign load_we = accept && (i_req.op == OP_LOAD)
                     && (32'(i_req.load_index) < MAX_ELEMENTS);

    tbs_mem #(.DEPTH(MAX_ELEMENTS), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (AW'(i_req.load_index)),
        .i_wdata (i_req.value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    tbs_search #(.AW(AW), .CW(CW)) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_etype (r_etype),
        .i_count (count_cl),
        .i_key   (i_req.value),
        .i_rdata (rdata),
        .o_raddr (raddr),
        .o_busy  (busy),
        .o_done  (done),
        .o_rsp   (srsp)
    );

    // Hold the response until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
        if (done) begin
            r_orsp <= srsp;
        end
    end

    assign o_valid = r_ovalid;
    assign o_rsp   = r_orsp;
endmodule

// ----- rtl/core/tbs_checker.sv -----
`include "typed_binary_search_unit_assert.svh"
module tbs_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input tbs_pkg::t_rsp o_rsp
);
    import tbs_pkg::*;

    // Not found always reports position zero
    `TBS_ASSERT_NOW(a_nf_pos, i_clk, i_rst_n, o_valid && !o_rsp.found, o_rsp.position == '0, "not-found position nonzero")
    // No new request while a response waits
    `TBS_ASSERT_NOW(a_no_accept, i_clk, i_rst_n, o_valid, !o_ready, "request taken with response pending")
    // Stalled response holds
    `TBS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_rsp), "response changed under stall")
endmodule

bind typed_binary_search_unit tbs_checker u_tbs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_rsp   (o_rsp)
);
